// ===== rtl/baf_pkg.sv =====
// Shared constants, codes and types of the box average filter.
`default_nettype none
package baf_pkg;

    localparam int DEF_MAX_WINDOW = 7;
    localparam int DEF_MAX_LINE   = 1024;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [2:0]            RST_WINDOW_SIZE = 3'd3;
    localparam logic [CFG_DATA_W-1:0] RST_LINE_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_LINE_COUNT  = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_LINE_WIDTH  = 2'd1,
        REG_LINE_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_FLUSH,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/baf_if.sv =====
// Handshake channel interfaces of the box average filter.
`default_nettype none
interface baf_pix_in_if;
    import baf_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [PIX_W-1:0]  pixel_in;
    modport source (output valid, output func, output pixel_in, input ready);
    modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface baf_pix_out_if;
    import baf_pkg::*;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pixel_out;
    logic              frame_last;
    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface baf_cfg_if;
    import baf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/box_average_filter.sv =====
// Top level of the box average filter: row store, window sequencer and divider.
//
//   Channel   Direction  Contents
//   pix_in    in         func, pixel_in
//   pix_out   out        pixel_out, frame_last
//   cfg       in         index, data (window_size, line_width, line_count)
//
// An item that releases no result passes through ST_IDLE and ST_CHECK. One
// that releases a result goes on through ST_READ, which reads the pixels of the
// clipped window one a cycle from the row store, ST_FLUSH, ST_DIV, which
// yields one quotient bit a cycle, and ST_FIN. A result waits in the output
// register while the next item is taken. Reset restores the register
// defaults and restarts the frame; the row store is not cleared.
`default_nettype none
module box_average_filter
    import baf_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_LINE   = DEF_MAX_LINE
)
(
    input  wire            clk,
    input  wire            rst_n,
    baf_pix_in_if.sink     pix_in,
    baf_pix_out_if.source  pix_out,
    baf_cfg_if.sink        cfg
);

    localparam int S    = MAX_WINDOW + 1;
    localparam int SW   = $clog2(S);
    localparam int PW   = $clog2(MAX_LINE);
    localparam int AMAX = (MAX_WINDOW - 1) / 2;
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int CW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUMW = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int STW  = $clog2(SUMW);
    localparam int DEPTH = S * (2 ** PW);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic             mem_we, rd_en;
    logic [SW+PW-1:0] waddr, raddr;

    state_t state_reg, state_next;
    logic [2:0]            window_size_reg, window_size_next;
    logic [CFG_DATA_W-1:0] line_width_reg, line_width_next;
    logic [CFG_DATA_W-1:0] line_count_reg, line_count_next;
    logic [PW-1:0] in_row_reg, in_row_next, in_col_reg, in_col_next;
    logic [PW-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [SW-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic          in_done_reg, in_done_next;
    logic [PW-1:0] cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [SW-1:0] cur_slot_reg, cur_slot_next;
    logic [PW-1:0] r1_reg, r1_next, c0_reg, c0_next, c1_reg, c1_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SUMW-1:0] sum_reg, sum_next, q_reg, q_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [STW-1:0] step_reg, step_next;
    logic          rd_valid_reg;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic          last_reg, last_next;
    logic          out_valid_reg, out_valid_next;

    // Clamped frame geometry and half window.
    logic [12:0]   lw_ext, lc_ext;
    logic [PW-1:0] wm1, hm1;
    logic [2:0]    a_raw, a;
    logic [PW:0]   rr_full, rc_full;
    logic [PW-1:0] rr, rc, r0, c0;
    logic [2:0]    d;
    logic [SW:0]   slot0;
    logic [WW-1:0] nr, nc;
    logic          win_ready, last_out;
    logic [CW:0]   tmp;

    always_comb
    begin
        lw_ext = 13'(line_width_reg);
        lc_ext = 13'(line_count_reg);
        if (lw_ext == 13'd0)
            wm1 = '0;
        else if (lw_ext > 13'(MAX_LINE))
            wm1 = PW'(MAX_LINE - 1);
        else
            wm1 = PW'(lw_ext - 13'd1);
        if (lc_ext == 13'd0)
            hm1 = '0;
        else if (lc_ext > 13'(MAX_LINE))
            hm1 = PW'(MAX_LINE - 1);
        else
            hm1 = PW'(lc_ext - 13'd1);
        a_raw = {1'b0, window_size_reg[2:1]};
        a = (a_raw > 3'(AMAX)) ? 3'(AMAX) : a_raw;

        rr_full = (PW+1)'(out_row_reg) + (PW+1)'(a);
        rc_full = (PW+1)'(out_col_reg) + (PW+1)'(a);
        rr = (rr_full > (PW+1)'(hm1)) ? hm1 : rr_full[PW-1:0];
        rc = (rc_full > (PW+1)'(wm1)) ? wm1 : rc_full[PW-1:0];
        if (out_row_reg >= PW'(a))
        begin
            r0 = out_row_reg - PW'(a);
            d  = a;
        end
        else
        begin
            r0 = '0;
            d  = out_row_reg[2:0];
        end
        c0 = (out_col_reg >= PW'(a)) ? out_col_reg - PW'(a) : '0;
        // Slot of the top window row, wrapping below slot zero.
        if ((SW+1)'(out_slot_reg) >= (SW+1)'(d))
            slot0 = (SW+1)'(out_slot_reg) - (SW+1)'(d);
        else
            slot0 = (SW+1)'(out_slot_reg) + (SW+1)'(S) - (SW+1)'(d);
        nr = WW'(rr - r0) + WW'(1);
        nc = WW'(rc - c0) + WW'(1);
        win_ready = in_done_reg || (in_row_reg > rr) || (in_row_reg == rr && in_col_reg > rc);
        last_out  = (out_row_reg == hm1) && (out_col_reg == wm1);
        tmp = {rem_reg, q_reg[SUMW-1]};
    end

    assign pix_in.ready  = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign pix_out.valid = out_valid_reg;
    assign pix_out.pixel_out  = pix_reg;
    assign pix_out.frame_last = last_reg;

    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        line_width_next  = line_width_reg;
        line_count_next  = line_count_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        in_done_next  = in_done_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        cur_slot_next = cur_slot_reg;
        r1_next  = r1_reg;
        c0_next  = c0_reg;
        c1_next  = c1_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        pix_next  = pix_reg;
        last_next = last_reg;
        out_valid_next = out_valid_reg && !pix_out.ready;
        mem_we = 1'b0;
        waddr  = {in_slot_reg, in_col_reg};
        rd_en  = 1'b0;
        raddr  = {cur_slot_reg, cur_col_reg};

        if (rd_valid_reg)
            sum_next = sum_reg + SUMW'(rdata_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_in.valid)
                begin
                    state_next = ST_CHECK;
                    if (pix_in.func == FUNC_PIXEL && !in_done_reg)
                    begin
                        mem_we = 1'b1;
                        if (in_col_reg == wm1)
                        begin
                            in_col_next = '0;
                            if (in_row_reg == hm1)
                                in_done_next = 1'b1;
                            else
                            begin
                                in_row_next  = in_row_reg + PW'(1);
                                in_slot_next = (in_slot_reg == SW'(S - 1)) ? '0
                                             : in_slot_reg + SW'(1);
                            end
                        end
                        else
                            in_col_next = in_col_reg + PW'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                if (win_ready)
                begin
                    cur_row_next  = r0;
                    cur_col_next  = c0;
                    cur_slot_next = slot0[SW-1:0];
                    r1_next  = rr;
                    c0_next  = c0;
                    c1_next  = rc;
                    cnt_next = CW'(nr) * CW'(nc);
                    sum_next = '0;
                    state_next = ST_READ;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (cur_col_reg == c1_reg)
                begin
                    cur_col_next = c0_reg;
                    if (cur_row_reg == r1_reg)
                        state_next = ST_FLUSH;
                    else
                    begin
                        cur_row_next  = cur_row_reg + PW'(1);
                        cur_slot_next = (cur_slot_reg == SW'(S - 1)) ? '0
                                      : cur_slot_reg + SW'(1);
                    end
                end
                else
                    cur_col_next = cur_col_reg + PW'(1);
            end
            ST_FLUSH:
            begin
                q_next    = sum_next;
                rem_next  = '0;
                step_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (tmp >= (CW+1)'(cnt_reg))
                begin
                    rem_next = CW'(tmp - (CW+1)'(cnt_reg));
                    q_next   = {q_reg[SUMW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = tmp[CW-1:0];
                    q_next   = {q_reg[SUMW-2:0], 1'b0};
                end
                step_next = step_reg + STW'(1);
                if (step_reg == STW'(SUMW - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || pix_out.ready)
                begin
                    pix_next  = q_reg[PIX_W-1:0];
                    last_next = last_out;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                    if (last_out)
                    begin
                        in_row_next = '0; in_col_next = '0; in_slot_next = '0;
                        out_row_next = '0; out_col_next = '0; out_slot_next = '0;
                        in_done_next = 1'b0;
                    end
                    else if (out_col_reg == wm1)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + PW'(1);
                        out_slot_next = (out_slot_reg == SW'(S - 1)) ? '0
                                      : out_slot_reg + SW'(1);
                    end
                    else
                        out_col_next = out_col_reg + PW'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_SIZE: window_size_next = cfg.data[2:0];
                REG_LINE_WIDTH:  line_width_next  = cfg.data;
                REG_LINE_COUNT:  line_count_next  = cfg.data;
                default: ;
            endcase
            if (cfg.index == REG_WINDOW_SIZE || cfg.index == REG_LINE_WIDTH
                || cfg.index == REG_LINE_COUNT)
            begin
                in_row_next = '0; in_col_next = '0; in_slot_next = '0;
                out_row_next = '0; out_col_next = '0; out_slot_next = '0;
                in_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= pix_in.pixel_in;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= RST_WINDOW_SIZE;
            line_width_reg  <= RST_LINE_WIDTH;
            line_count_reg  <= RST_LINE_COUNT;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            line_width_reg  <= line_width_next;
            line_count_reg  <= line_count_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            in_done_reg  <= in_done_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg  <= cur_row_next;
        cur_col_reg  <= cur_col_next;
        cur_slot_reg <= cur_slot_next;
        r1_reg  <= r1_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        cnt_reg <= cnt_next;
        sum_reg <= sum_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        step_reg <= step_next;
        pix_reg  <= pix_next;
        last_reg <= last_next;
    end

    // Read data only arrives in the cycle after an address was issued.
    a_rd_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_READ))
        else $error("row store data without a read");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("window count is zero in divider");

    // Outputs never run ahead of the input raster.
    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        !in_done_reg |-> out_row_reg <= in_row_reg)
        else $error("output row ahead of input row");

    a_slots_track: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg == '0 |-> in_slot_reg == '0)
        else $error("input slot out of step with row");

endmodule
`default_nettype wire
